// ===== design/khl_pkg.sv =====
`timescale 1ns / 1ps

package khl_pkg;

  // Window depth, in bytes, and the fixed tag capacity.
  localparam int MAX_KEYWORD = 8;
  localparam int TAG_BYTES   = 8;

  // Byte count of the window, able to hold MAX_KEYWORD itself.
  localparam int CNT_W = $clog2(MAX_KEYWORD + 1);
  // Step counter covering both tag bytes and keyword bytes.
  localparam int SEQ_W = $clog2(TAG_BYTES);

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYWORD_BYTES    = 3'd0,
    REG_KEYWORD_LENGTH   = 3'd1,
    REG_OPEN_TAG_BYTES   = 3'd2,
    REG_OPEN_TAG_LENGTH  = 3'd3,
    REG_CLOSE_TAG_BYTES  = 3'd4,
    REG_CLOSE_TAG_LENGTH = 3'd5
  } reg_idx_t;

  // Emission sequencer states.
  typedef enum logic [2:0] {
    ST_RUN,
    ST_OPEN,
    ST_KEY,
    ST_CLOSE,
    ST_FLUSH
  } state_t;

  // Per-cell control: load the incoming byte here, or take the neighbor's byte.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  // Effective keyword length: zero reads as one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_key_len(input logic [3:0] raw);
    logic [CNT_W-1:0] k;
    if (raw == 4'd0) begin
      k = CNT_W'(1);
    end else if (32'(raw) > MAX_KEYWORD) begin
      k = CNT_W'(MAX_KEYWORD);
    end else begin
      k = CNT_W'(raw);
    end
    return k;
  endfunction

  // Effective tag length: saturates at the tag capacity.
  function automatic logic [3:0] eff_tag_len(input logic [3:0] raw);
    logic [3:0] n;
    if (32'(raw) > TAG_BYTES) begin
      n = 4'(TAG_BYTES);
    end else begin
      n = raw;
    end
    return n;
  endfunction

endpackage

// ===== design/khl_if.sv =====
`timescale 1ns / 1ps

// Text byte channel into the tagger.
interface khl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

// Highlighted byte channel out of the tagger.
interface khl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;

  modport source (output valid, output out_byte, output out_end, input ready);
  modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

// ===== design/keyword_highlight_tagger_core.sv =====
`timescale 1ns / 1ps

// Channel    | Dir | Payload                | Transfer
// -----------+-----+------------------------+--------------------------
// text_in    | in  | text_byte, text_end    | valid && ready at clk rise
// text_out   | out | out_byte, out_end      | valid && ready at clk rise
// cfg        | in  | cfg_idx, cfg_data      | cfg_we at clk rise
//
// For a byte that does not complete a keyword match, the window compare, the
// head pop and the output register load all happen in the cycle it is accepted.
// A match holds the input while the open tag, keyword and close tag are emitted,
// and an end marker holds it further while the window's bytes are flushed.
// Every emitted byte needs a free output register, so a stall on text_out
// stalls text_in. Reset (rst, synchronous) empties the window and the output.
module keyword_highlight_tagger_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [khl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [khl_pkg::CFG_DATA_W-1:0] cfg_data,
  khl_in_if.sink                         text_in,
  khl_out_if.source                      text_out
);

  localparam int N = khl_pkg::MAX_KEYWORD;
  localparam int CW = khl_pkg::CNT_W;
  localparam int SW = khl_pkg::SEQ_W;

  // Configuration registers, kept in effective form.
  logic [8*N-1:0]                         keyword;
  logic [CW-1:0]                          key_len;
  logic [8*khl_pkg::TAG_BYTES-1:0]        open_tag;
  logic [3:0]                             open_len;
  logic [8*khl_pkg::TAG_BYTES-1:0]        close_tag;
  logic [3:0]                             close_len;

  // Sequencer and window state.
  khl_pkg::state_t state, state_next;
  logic [SW-1:0]   idx, idx_next;
  logic [CW-1:0]   count, count_next;
  logic            last_q, last_q_next;

  // Output register.
  logic       ovalid;
  logic [7:0] obyte;
  logic       oend;

  // Cell row signals.
  khl_pkg::cell_ctl_t ctl [N];
  logic [7:0]         appended [N+1];
  logic [N-1:0]       hits;

  logic          load_ok;
  logic          accept;
  logic [CW-1:0] cnt_a;
  logic          decide;
  logic          match;
  logic          pop;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_end;
  logic          key_done;
  logic          open_done;
  logic          close_done;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      keyword   <= '0;
      key_len   <= CW'(1);
      open_tag  <= '0;
      open_len  <= '0;
      close_tag <= '0;
      close_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        khl_pkg::REG_KEYWORD_BYTES:    keyword   <= cfg_data[8*N-1:0];
        khl_pkg::REG_KEYWORD_LENGTH:   key_len   <= khl_pkg::eff_key_len(cfg_data[3:0]);
        khl_pkg::REG_OPEN_TAG_BYTES:   open_tag  <= cfg_data;
        khl_pkg::REG_OPEN_TAG_LENGTH:  open_len  <= khl_pkg::eff_tag_len(cfg_data[3:0]);
        khl_pkg::REG_CLOSE_TAG_BYTES:  close_tag <= cfg_data;
        khl_pkg::REG_CLOSE_TAG_LENGTH: close_len <= khl_pkg::eff_tag_len(cfg_data[3:0]);
        default: ;
      endcase
    end
  end

  // Handshake on both sides.
  assign load_ok       = !ovalid || text_out.ready;
  assign text_in.ready = (state == khl_pkg::ST_RUN) && load_ok;
  assign accept        = text_in.valid && text_in.ready;

  // Row of window cells; the last cell shifts in zero.
  assign appended[N] = '0;
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign ctl[i].insert = accept && (count == CW'(i));
    assign ctl[i].shift  = pop;

    khl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .in_byte    (text_in.text_byte),
      .right_byte (appended[i+1]),
      .key_byte   (keyword[8*i +: 8]),
      .active     (CW'(i) < key_len),
      .appended   (appended[i]),
      .hit        (hits[i])
    );
  end

  // Window decision on the appended contents.
  assign cnt_a      = count + CW'(1);
  assign decide     = accept && (cnt_a >= key_len);
  assign match      = decide && (&hits);
  assign key_done   = (idx == SW'(key_len - CW'(1)));
  assign open_done  = (idx == SW'(open_len - 4'd1));
  assign close_done = (idx == SW'(close_len - 4'd1));

  // Next state of the emission sequencer.
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    last_q_next = last_q;
    unique case (state)
      khl_pkg::ST_RUN: begin
        if (accept) begin
          last_q_next = text_in.text_end;
          idx_next    = '0;
          if (match) begin
            state_next = (open_len != 4'd0) ? khl_pkg::ST_OPEN : khl_pkg::ST_KEY;
          end else if (decide) begin
            if (text_in.text_end && (count != '0)) begin
              state_next = khl_pkg::ST_FLUSH;
            end
          end else if (text_in.text_end) begin
            state_next = khl_pkg::ST_FLUSH;
          end
        end
      end
      khl_pkg::ST_OPEN: begin
        if (load_ok) begin
          if (open_done) begin
            state_next = khl_pkg::ST_KEY;
            idx_next   = '0;
          end else begin
            idx_next = idx + SW'(1);
          end
        end
      end
      khl_pkg::ST_KEY: begin
        if (load_ok) begin
          if (key_done) begin
            idx_next = '0;
            if (close_len != 4'd0) begin
              state_next = khl_pkg::ST_CLOSE;
            end else if (last_q && (count != CW'(1))) begin
              state_next = khl_pkg::ST_FLUSH;
            end else begin
              state_next = khl_pkg::ST_RUN;
            end
          end else begin
            idx_next = idx + SW'(1);
          end
        end
      end
      khl_pkg::ST_CLOSE: begin
        if (load_ok) begin
          if (close_done) begin
            idx_next   = '0;
            state_next = (last_q && (count != '0)) ? khl_pkg::ST_FLUSH : khl_pkg::ST_RUN;
          end else begin
            idx_next = idx + SW'(1);
          end
        end
      end
      khl_pkg::ST_FLUSH: begin
        if (load_ok && (count == CW'(1))) begin
          state_next = khl_pkg::ST_RUN;
        end
      end
      default: state_next = khl_pkg::ST_RUN;
    endcase
  end

  // Emitted byte, window pop and count update for the current state.
  always_comb begin
    emit       = 1'b0;
    emit_byte  = appended[0];
    emit_end   = 1'b0;
    pop        = 1'b0;
    count_next = count;
    unique case (state)
      khl_pkg::ST_RUN: begin
        if (accept) begin
          if (decide && !match) begin
            emit       = 1'b1;
            pop        = 1'b1;
            emit_end   = text_in.text_end && (count == '0);
            count_next = count;
          end else begin
            count_next = cnt_a;
          end
        end
      end
      khl_pkg::ST_OPEN: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_byte = open_tag[8*idx +: 8];
        end
      end
      khl_pkg::ST_KEY: begin
        if (load_ok) begin
          emit       = 1'b1;
          pop        = 1'b1;
          count_next = count - CW'(1);
          emit_end   = key_done && last_q && (close_len == 4'd0) && (count == CW'(1));
        end
      end
      khl_pkg::ST_CLOSE: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_byte = close_tag[8*idx +: 8];
          emit_end  = close_done && last_q && (count == '0);
        end
      end
      khl_pkg::ST_FLUSH: begin
        if (load_ok) begin
          emit       = 1'b1;
          pop        = 1'b1;
          count_next = count - CW'(1);
          emit_end   = (count == CW'(1));
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= khl_pkg::ST_RUN;
      idx    <= '0;
      count  <= '0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      count  <= count_next;
      last_q <= last_q_next;
    end
  end

  // Output register: loads whenever it is empty or its byte is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_ok) begin
      ovalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && emit) begin
      obyte <= emit_byte;
      oend  <= emit_end;
    end
  end

  assign text_out.valid    = ovalid;
  assign text_out.out_byte = obyte;
  assign text_out.out_end  = oend;

endmodule

// ===== design/khl_cell.sv =====
`timescale 1ns / 1ps

// One window slot: holds a byte, takes the incoming byte or the byte of its
// right neighbor, and compares its byte with its keyword byte.
module khl_cell (
  input  logic               clk,
  input  khl_pkg::cell_ctl_t ctl,
  input  logic [7:0]         in_byte,
  input  logic [7:0]         right_byte,
  input  logic [7:0]         key_byte,
  input  logic               active,
  output logic [7:0]         appended,
  output logic               hit
);

  logic [7:0] held;

  // Byte seen after the current transfer is appended.
  assign appended = ctl.insert ? in_byte : held;

  // Slots beyond the keyword length never block a match.
  assign hit = !active || (appended == key_byte);

  // Shift toward the head on a pop, otherwise keep the appended byte.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= right_byte;
    end else begin
      held <= appended;
    end
  end

endmodule
